// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, skipped while reset is high.
`define AEF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define AEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/aef_pkg.sv =====
`default_nettype none

package aef_pkg;

   localparam int BYTE_W      = 8;
   localparam int CELL_CAP_W  = 12;
   localparam int CSR_INDEX_W = 1;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_MODE     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_CELL_CAP = 1'b1;

   localparam logic                  MODE_STRIP     = 1'b0;
   localparam logic                  MODE_TRUNCATE  = 1'b1;
   localparam logic [CELL_CAP_W-1:0] CELL_CAP_RESET = 12'd80;

   localparam logic [BYTE_W-1:0] ESC_BYTE       = 8'h1B;
   localparam logic [BYTE_W-1:0] BEL_BYTE       = 8'h07;
   localparam logic [BYTE_W-1:0] CSI_INTRO      = 8'h5B;
   localparam logic [BYTE_W-1:0] OSC_INTRO      = 8'h5D;
   localparam logic [BYTE_W-1:0] ST_BACKSLASH   = 8'h5C;
   localparam logic [BYTE_W-1:0] CSI_FINAL_LO   = 8'h40;
   localparam logic [BYTE_W-1:0] CSI_FINAL_HI   = 8'h7E;
   localparam logic [BYTE_W-1:0] CTRL_LIMIT     = 8'h20;
   localparam logic [BYTE_W-1:0] HIGH_BIT       = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK     = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE     = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK     = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE     = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK     = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE     = 8'hF0;

   // SGR reset sent after a cut line: ESC [ 0 m
   localparam int BURST_BEAT_W = 2;
   localparam logic [BURST_BEAT_W-1:0] BURST_LAST_BEAT = 2'd3;
   localparam logic [BYTE_W-1:0] RESET_SEQ [4] = '{8'h1B, 8'h5B, 8'h30, 8'h6D};

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_BARE,
      KIND_BURST
   } aef_kind_type;

   // What one input byte leaves for the output stage
   typedef struct packed {
      aef_kind_type      kind;
      logic [BYTE_W-1:0] data;
      logic              line_end;
   } aef_result_type;

endpackage

`default_nettype wire

// ===== design/aef_core.sv =====
`default_nettype none

module aef_core import aef_pkg::*; #(
   parameter int CELL_COUNT_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_i,
   input  wire logic [BYTE_W-1:0]     byte_i,
   input  wire logic                  last_i,
   input  wire logic                  mode_i,
   input  wire logic [CELL_CAP_W-1:0] cell_cap_i,
   output aef_result_type             result_o,
   output logic                       result_valid_o
);

   localparam int LIM_W = (CELL_COUNT_BITS > CELL_CAP_W) ? CELL_COUNT_BITS : CELL_CAP_W;

   typedef enum logic [2:0] {
      PH_PLAIN,
      PH_ESC,
      PH_CSI,
      PH_OSC,
      PH_OSC_ESC
   } phase_type;

   phase_type                  phase_ff, phase_in, esc_phase;
   logic [1:0]                 cont_ff, cont_in, lead_cont;
   logic [CELL_COUNT_BITS-1:0] cells_ff, cells_in, limit;
   logic                       cut_ff, cut_in;
   logic                       esc_hit, emit, width_one, over;
   logic [LIM_W-1:0]           cap_in_ext, cap_ext;
   logic [CELL_COUNT_BITS:0]   cells_sum;

   // Saturate the limit to the counter range
   assign cap_in_ext = LIM_W'(cell_cap_i);
   assign cap_ext    = LIM_W'({CELL_COUNT_BITS{1'b1}});
   assign limit      = (cap_in_ext > cap_ext) ? CELL_COUNT_BITS'(cap_ext)
                                              : CELL_COUNT_BITS'(cap_in_ext);

   // Escape parser step
   always_comb begin
      esc_phase = PH_PLAIN;
      esc_hit   = 1'b1;
      case (phase_ff)
         PH_ESC: begin
            if (byte_i == CSI_INTRO)      esc_phase = PH_CSI;
            else if (byte_i == OSC_INTRO) esc_phase = PH_OSC;
            else                          esc_phase = PH_PLAIN;
         end
         PH_CSI: begin
            esc_phase = (byte_i inside {[CSI_FINAL_LO:CSI_FINAL_HI]}) ? PH_PLAIN : PH_CSI;
         end
         PH_OSC: begin
            if (byte_i == BEL_BYTE)      esc_phase = PH_PLAIN;
            else if (byte_i == ESC_BYTE) esc_phase = PH_OSC_ESC;
            else                         esc_phase = PH_OSC;
         end
         PH_OSC_ESC: begin
            if (byte_i == ST_BACKSLASH || byte_i == BEL_BYTE) esc_phase = PH_PLAIN;
            else if (byte_i == ESC_BYTE)                      esc_phase = PH_OSC_ESC;
            else                                              esc_phase = PH_OSC;
         end
         default: begin
            esc_hit   = (byte_i == ESC_BYTE);
            esc_phase = esc_hit ? PH_ESC : PH_PLAIN;
         end
      endcase
   end

   // Cell width and UTF-8 trail length
   always_comb begin
      lead_cont = 2'd0;
      width_one = 1'b1;
      if (byte_i >= HIGH_BIT) begin
         if ((byte_i & LEAD2_MASK) == LEAD2_CODE)      lead_cont = 2'd1;
         else if ((byte_i & LEAD3_MASK) == LEAD3_CODE) lead_cont = 2'd2;
         else if ((byte_i & LEAD4_MASK) == LEAD4_CODE) lead_cont = 2'd3;
      end else if (byte_i < CTRL_LIMIT) begin
         width_one = 1'b0;
      end
   end

   assign cells_sum = {1'b0, cells_ff} + (CELL_COUNT_BITS+1)'(width_one);
   assign over      = cells_sum > {1'b0, limit};

   always_comb begin
      phase_in = phase_ff;
      cont_in  = cont_ff;
      cells_in = cells_ff;
      cut_in   = cut_ff;
      emit     = 1'b0;
      if (mode_i == MODE_STRIP) begin
         phase_in = esc_phase;
         emit     = !esc_hit;
      end else if (limit == '0 || cut_ff) begin
         // drop everything on a cut line or a zero limit
         emit = 1'b0;
      end else if (phase_ff == PH_PLAIN && cont_ff != 2'd0) begin
         emit    = 1'b1;
         cont_in = cont_ff - 2'd1;
      end else if (esc_hit) begin
         emit     = 1'b1;
         phase_in = esc_phase;
      end else begin
         phase_in = esc_phase;
         if (over) begin
            cut_in = 1'b1;
         end else begin
            emit     = 1'b1;
            cells_in = cells_sum[CELL_COUNT_BITS-1:0];
            cont_in  = lead_cont;
         end
      end

      result_o.data     = byte_i;
      result_o.line_end = last_i;
      result_o.kind     = KIND_BYTE;
      result_valid_o    = emit;
      if (last_i) begin
         result_valid_o = 1'b1;
         if (mode_i == MODE_TRUNCATE && cut_in) begin
            result_o.kind = KIND_BURST;
         end else if (!emit) begin
            result_o.kind = KIND_BARE;
            result_o.data = '0;
         end
         phase_in = PH_PLAIN;
         cont_in  = 2'd0;
         cells_in = '0;
         cut_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         cont_ff  <= 2'd0;
         cells_ff <= '0;
         cut_ff   <= 1'b0;
      end else if (step_i) begin
         phase_ff <= phase_in;
         cont_ff  <= cont_in;
         cells_ff <= cells_in;
         cut_ff   <= cut_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/aef_out.sv =====
`default_nettype none

module aef_out import aef_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_i,
   input  wire aef_result_type    result_i,
   output logic                   free_o,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [BYTE_W-1:0]      rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   aef_result_type          res_ff;
   logic                    valid_ff;
   logic [BURST_BEAT_W-1:0] beat_ff;
   logic                    is_burst, last_beat, fire, done;

   assign is_burst  = (res_ff.kind == KIND_BURST);
   assign last_beat = !is_burst || (beat_ff == BURST_LAST_BEAT);
   assign fire      = valid_ff && rsp_tready;
   assign done      = fire && last_beat;
   assign free_o    = !valid_ff || done;

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = is_burst ? RESET_SEQ[beat_ff] : res_ff.data;
   assign rsp_tuser[0] = (res_ff.kind != KIND_BARE);
   assign rsp_tuser[1] = is_burst;
   assign rsp_tlast    = res_ff.line_end && last_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else if (load_i) begin
         valid_ff <= 1'b1;
         beat_ff  <= '0;
      end else if (done) begin
         valid_ff <= 1'b0;
      end else if (fire) begin
         beat_ff <= beat_ff + BURST_BEAT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         res_ff <= result_i;
      end
   end

endmodule

`default_nettype wire

// ===== design/ansi_escape_filter_unit.sv =====
`default_nettype none

// Channel   | Dir | Payload                                     | Notes
// req_*     | in  | tdata[7:0] in_byte, tlast line_last         | one request per raw byte
// rsp_*     | out | tdata[7:0] out_byte, tuser has_byte/was_trunc,| 0..4 responses per request
//           |     | tlast line_end                              |
// csr_*     | in  | index 0 mode, index 1 cell cap              | write only, idle block
//
// One request is taken per cycle unless the result register is busy; a request passes
// the input register, then the result register, before its first response.
// A line cut in truncate mode holds the input while the output register plays
// out the four-byte SGR reset.
// Stalls on rsp_ freeze the result register; the input register then fills and
// req_tready drops. Reset is synchronous and needs no clearing pass.

module ansi_escape_filter_unit import aef_pkg::*; #(
   parameter int CELL_COUNT_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,   // [7:0] in_byte
   input  wire logic                   req_tlast,
   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [BYTE_W-1:0]           rsp_tdata,   // [7:0] out_byte
   output logic [1:0]                  rsp_tuser,   // [0] has_byte, [1] was_truncated
   output logic                        rsp_tlast,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CELL_CAP_W-1:0]  csr_wdata
);

   logic                  mode_ff;
   logic [CELL_CAP_W-1:0] cell_cap_ff;
   logic                  in_valid_ff;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic                  in_last_ff;
   logic                  out_free, step;
   aef_result_type        result;
   logic                  result_valid;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_STRIP;
         cell_cap_ff <= CELL_CAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IDX_MODE:     mode_ff     <= csr_wdata[0];
            CSR_IDX_CELL_CAP: cell_cap_ff <= csr_wdata;
            default:          mode_ff     <= mode_ff;
         endcase
      end
   end

   // Advance the held byte whenever the result register can take its outcome;
   // bytes that produce nothing advance regardless.
   assign step       = in_valid_ff && (out_free || !result_valid);
   assign req_tready = !in_valid_ff || step;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Parser, cell counter and line-end decision
   aef_core #(
      .CELL_COUNT_BITS (CELL_COUNT_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step_i         (step),
      .byte_i         (in_byte_ff),
      .last_i         (in_last_ff),
      .mode_i         (mode_ff),
      .cell_cap_i     (cell_cap_ff),
      .result_o       (result),
      .result_valid_o (result_valid)
   );

   // Result register and reset-sequence playout
   aef_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_i     (step && result_valid),
      .result_i   (result),
      .free_o     (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== design/aef_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module aef_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // A stalled response holds
   `AEF_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response changed while stalled")

   // Reset-sequence bytes always carry data
   `AEF_ASSERT(a_trunc_has_byte, clock, reset, rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0], "truncation flag on a bare marker")

   // A bare marker is zero and closes the line
   `AEF_ASSERT(a_bare_marker, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 8'h00, "malformed bare line end")

   // No response right out of reset
   `AEF_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid, "response valid after reset")

endmodule

bind ansi_escape_filter_unit aef_checker u_aef_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/tb_ansi_escape_filter_unit.sv =====
module tb_ansi_escape_filter_unit import aef_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Wait after the last expected response before a register write or the end:
   // two pipeline stages plus the three extra beats of a reset burst, with margin.
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 60;
   localparam int RANDOM_ITEMS  = 140;
   localparam int CYCLE_LIMIT   = 100000;
   localparam int IDLE_PCT      = 15;

   // Escape scanner states
   typedef enum logic [2:0] {
      SCAN_TEXT,
      SCAN_ESC,
      SCAN_CSI,
      SCAN_OSC,
      SCAN_OSC_ESC
   } scan_state_type;

   // One response as seen on rsp_*
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              has;
      logic              eol;
      logic              cut;
   } filtered_beat_type;

   // One row of the directed part: either a register write or a request.
   // Rows with typed set carry the single response they must produce.
   typedef struct packed {
      logic                   cfg;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CELL_CAP_W-1:0]  val;
      logic [BYTE_W-1:0]      data;
      logic                   last;
      logic                   typed;
      filtered_beat_type      want;
   } stim_row_type;

   localparam filtered_beat_type NO_BEAT = '0;
   localparam int N_ROWS = 32;

   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // strip mode, reset settings: plain byte passes
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}},
      // CSI with a parameter, dropped whole
      '{1'b0, CSR_IDX_MODE, 12'd0, ESC_BYTE,  1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, CSI_INTRO, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h31,     1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h6D,     1'b0, 1'b0, NO_BEAT},
      // OSC with a stray ESC inside, closed by BEL
      '{1'b0, CSR_IDX_MODE, 12'd0, ESC_BYTE,  1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, OSC_INTRO, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, ESC_BYTE,  1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h71,     1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, BEL_BYTE,  1'b0, 1'b0, NO_BEAT},
      // two-byte escape
      '{1'b0, CSR_IDX_MODE, 12'd0, ESC_BYTE,  1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h63,     1'b0, 1'b0, NO_BEAT},
      // top byte value ends the line
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
      // unterminated escape at line end: bare marker only
      '{1'b0, CSR_IDX_MODE, 12'd0, ESC_BYTE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      // truncate to two cells
      '{1'b1, CSR_IDX_MODE,     12'd1, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b1, CSR_IDX_CELL_CAP, 12'd2, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h01,    1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h61,    1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'hC3,    1'b0, 1'b0, NO_BEAT},
      // continuation copied blindly even though it is ESC
      '{1'b0, CSR_IDX_MODE, 12'd0, ESC_BYTE, 1'b0, 1'b0, NO_BEAT},
      // third cell cuts the line; reset burst follows at line end
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h62,    1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h63,    1'b1, 1'b0, NO_BEAT},
      // zero limit: everything dropped, bare marker
      '{1'b1, CSR_IDX_CELL_CAP, 12'd0, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h7A, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      // largest limit; OSC closed by ESC backslash, then a four-byte lead
      '{1'b1, CSR_IDX_CELL_CAP, 12'hFFF, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, ESC_BYTE,     1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, OSC_INTRO,    1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, ESC_BYTE,     1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, ST_BACKSLASH, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'hF0,        1'b0, 1'b0, NO_BEAT},
      // switch to strip mid-line: pending continuations no longer matter
      '{1'b1, CSR_IDX_MODE, 12'd0, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, CSR_IDX_MODE, 12'd0, 8'h80, 1'b1, 1'b0, NO_BEAT}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [BYTE_W-1:0]      rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CELL_CAP_W-1:0]  csr_wdata;

   // Shadow copy of the registers and the line state
   logic                   cfg_mode;
   logic [CELL_CAP_W-1:0]  cfg_cell_cap;
   scan_state_type         scan;
   logic [1:0]             cont_left;
   logic [CELL_CAP_W-1:0]  cells_used;
   logic                   line_cut;

   filtered_beat_type expected_beats [$];
   filtered_beat_type pred_buf [4];
   logic [BYTE_W-1:0] line_bytes [$];

   int  err_count;
   int  cycle_count;
   bit  steady;     // no idling on either side while set
   bit  hold_req;   // ask the receiver for one long hold-off

   ansi_escape_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      err_count++;
   endtask

   // Append one byte to the line under construction
   function automatic void append_byte(input logic [BYTE_W-1:0] b);
      line_bytes = {line_bytes, b};
   endfunction

   // Advance the escape scanner by one byte; return 1 if the byte is part of an
   // escape sequence.
   function automatic logic scan_escape(input logic [BYTE_W-1:0] b);
      case (scan)
         SCAN_ESC: begin
            if (b == CSI_INTRO) scan = SCAN_CSI;
            else if (b == OSC_INTRO) scan = SCAN_OSC;
            else scan = SCAN_TEXT;
            return 1'b1;
         end
         SCAN_CSI: begin
            if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI) scan = SCAN_TEXT;
            return 1'b1;
         end
         SCAN_OSC: begin
            if (b == BEL_BYTE) scan = SCAN_TEXT;
            else if (b == ESC_BYTE) scan = SCAN_OSC_ESC;
            return 1'b1;
         end
         SCAN_OSC_ESC: begin
            // only backslash or BEL close it; another ESC keeps waiting
            if (b == ST_BACKSLASH || b == BEL_BYTE) scan = SCAN_TEXT;
            else if (b != ESC_BYTE) scan = SCAN_OSC;
            return 1'b1;
         end
         default: begin
            if (b == ESC_BYTE) begin
               scan = SCAN_ESC;
               return 1'b1;
            end
            scan = SCAN_TEXT;
            return 1'b0;
         end
      endcase
   endfunction

   // Work out the responses one request causes; they land in pred_buf.
   function automatic int predict_filter(input logic [BYTE_W-1:0] b, input logic last);
      int          n;
      int unsigned limit;
      int unsigned w;
      int unsigned len;
      n = 0;
      if (cfg_mode == MODE_STRIP) begin
         if (!scan_escape(b)) begin
            pred_buf[n] = '{b, 1'b1, 1'b0, 1'b0};
            n++;
         end
      end else begin
         limit = cfg_cell_cap;
         if (limit == 0 || line_cut) begin
            // dropped
         end else if (scan == SCAN_TEXT && cont_left != 0) begin
            pred_buf[n] = '{b, 1'b1, 1'b0, 1'b0};
            n++;
            cont_left--;
         end else if (scan_escape(b)) begin
            pred_buf[n] = '{b, 1'b1, 1'b0, 1'b0};
            n++;
         end else begin
            len = 1;
            w   = 1;
            if (b >= HIGH_BIT) begin
               if ((b & LEAD2_MASK) == LEAD2_CODE) len = 2;
               else if ((b & LEAD3_MASK) == LEAD3_CODE) len = 3;
               else if ((b & LEAD4_MASK) == LEAD4_CODE) len = 4;
            end else if (b < CTRL_LIMIT) begin
               w = 0;
            end
            if (cells_used + w > limit) begin
               line_cut = 1'b1;
            end else begin
               pred_buf[n] = '{b, 1'b1, 1'b0, 1'b0};
               n++;
               cells_used = CELL_CAP_W'(cells_used + w);
               cont_left  = 2'(len - 1);
            end
         end
      end
      if (last) begin
         if (cfg_mode == MODE_TRUNCATE && line_cut) begin
            for (int i = 0; i < 4; i++) begin
               pred_buf[n] = '{RESET_SEQ[i], 1'b1, 1'b0, 1'b1};
               n++;
            end
         end
         if (n == 0) begin
            pred_buf[n] = '{8'h00, 1'b0, 1'b0, 1'b0};
            n++;
         end
         pred_buf[n-1].eol = 1'b1;
         scan       = SCAN_TEXT;
         cont_left  = '0;
         cells_used = '0;
         line_cut   = 1'b0;
      end
      return n;
   endfunction

   // Offer one request, hold it until accepted, then queue what it must produce.
   task automatic send_request(input logic [BYTE_W-1:0] b, input logic last,
                               input logic typed, input filtered_beat_type want);
      int n;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      n = predict_filter(b, last);
      if (typed) begin
         expected_beats = {expected_beats, want};
      end else begin
         for (int i = 0; i < n; i++) expected_beats = {expected_beats, pred_buf[i]};
      end
   endtask

   // Drop valid, drain every expected response, then give the pipeline time to
   // finish requests that produce nothing.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CELL_CAP_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_IDX_MODE) cfg_mode = val[0];
      else cfg_cell_cap = val;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Build one line out of mostly well-formed pieces, with some noise, and send it.
   task automatic send_random_line(output int sent);
      int target;
      int kind;
      int len;
      target = $urandom_range(1, 14);
      line_bytes.delete();
      while (line_bytes.size() < target) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            append_byte(8'($urandom_range(8'h20, 8'h7E)));
         end else if (kind < 55) begin
            // CSI: parameters then a final byte
            append_byte(ESC_BYTE);
            append_byte(CSI_INTRO);
            repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(8'h30, 8'h3F)));
            append_byte(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
         end else if (kind < 65) begin
            // OSC: payload, closed by BEL or ESC backslash
            append_byte(ESC_BYTE);
            append_byte(OSC_INTRO);
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(9) == 0) append_byte(ESC_BYTE);
               else append_byte(8'($urandom_range(8'h20, 8'h7E)));
            end
            if ($urandom_range(1)) begin
               append_byte(BEL_BYTE);
            end else begin
               append_byte(ESC_BYTE);
               append_byte(ST_BACKSLASH);
            end
         end else if (kind < 80) begin
            // UTF-8 character of two to four bytes
            len = $urandom_range(2, 4);
            if (len == 2) append_byte(LEAD2_CODE | 8'($urandom_range(0, 31)));
            else if (len == 3) append_byte(LEAD3_CODE | 8'($urandom_range(0, 15)));
            else append_byte(LEAD4_CODE | 8'($urandom_range(0, 7)));
            repeat (len - 1) append_byte(HIGH_BIT | 8'($urandom_range(0, 63)));
         end else if (kind < 88) begin
            append_byte(8'($urandom_range(0, 8'h1F)));
         end else if (kind < 92) begin
            append_byte(ESC_BYTE);
            append_byte(8'($urandom_range(0, 255)));
         end else begin
            append_byte(8'($urandom_range(0, 255)));
         end
      end
      // sometimes cut the line short so a sequence is left open at line end
      if ($urandom_range(9) == 0 && line_bytes.size() > 1)
         line_bytes = line_bytes[0:$urandom_range(0, line_bytes.size() - 2)];
      foreach (line_bytes[i])
         send_request(line_bytes[i], i == line_bytes.size() - 1, 1'b0, NO_BEAT);
      sent = line_bytes.size();
   endtask

   // Check every accepted response against the oldest expectation
   always @(posedge clock) begin : rsp_check
      filtered_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected response data=%02h user=%b last=%b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch($sformatf("out_byte %02h, want %02h", rsp_tdata, want.data));
            if (rsp_tuser[0] !== want.has)
               report_mismatch($sformatf("has_byte %b, want %b", rsp_tuser[0], want.has));
            if (rsp_tlast !== want.eol)
               report_mismatch($sformatf("line_end %b, want %b", rsp_tlast, want.eol));
            if (rsp_tuser[1] !== want.cut)
               report_mismatch($sformatf("was_truncated %b, want %b", rsp_tuser[1], want.cut));
         end
      end
   end

   // Watchdog: stop a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_beats.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver pacing: random stalls, none while steady, one long hold-off on
   // request so the block backs up into its input.
   initial begin : rx_pacing
      int k;
      rsp_tready <= 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      int sent;
      int items;
      int phase;
      int pick;
      logic [CELL_CAP_W-1:0] limit_val;

      clock       = 1'b0;
      reset       = 1'b1;
      err_count   = 0;
      cycle_count = 0;
      steady      = 1'b0;
      hold_req    = 1'b0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;

      // Shadow state matches the block after reset
      cfg_mode     = MODE_STRIP;
      cfg_cell_cap = CELL_CAP_RESET;
      scan         = SCAN_TEXT;
      cont_left    = '0;
      cells_used   = '0;
      line_cut     = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: register writes happen only on a drained block
      for (int r = 0; r < N_ROWS; r++) begin
         if (DIRECTED_ROWS[r].cfg) begin
            drain_block();
            write_csr(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].val);
         end else begin
            send_request(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
         end
      end

      // Random phases, each with fresh settings; small limits dominate so that
      // lines get cut often.
      items = 0;
      phase = 0;
      while (items < RANDOM_ITEMS) begin
         drain_block();
         pick = $urandom_range(9);
         case (pick)
            0:       limit_val = '0;
            1:       limit_val = '1;
            2:       limit_val = 12'd1;
            3, 4, 5, 6: limit_val = 12'($urandom_range(2, 12));
            default: limit_val = 12'($urandom_range(0, 4095));
         endcase
         // phase one runs in strip mode so every byte outside an escape sequence yields
         // output while the receiver holds off
         write_csr(CSR_IDX_MODE, (phase == 1) ? 12'(MODE_STRIP) : 12'($urandom_range(1)));
         write_csr(CSR_IDX_CELL_CAP, limit_val);
         steady = (phase == 0 || phase == 2);
         if (phase == 1) hold_req = 1'b1;
         repeat ($urandom_range(3, 6)) begin
            send_random_line(sent);
            items += sent;
         end
         phase++;
      end

      steady = 1'b0;
      drain_block();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== ansi_escape_filter_unit.f =====
+incdir+design
design/aef_pkg.sv
design/aef_core.sv
design/aef_out.sv
design/ansi_escape_filter_unit.sv
design/aef_checker.sv
tb/tb_ansi_escape_filter_unit.sv
